/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_CHANGE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                  upd;     // apply this operation
    logic                  rm;      // close the gap at idx
    logic                  ins;     // place key/value at its sorted position
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      cnt_rm;  // occupancy once the gap is closed
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      cell_pos,
  input  cmd_t                  cmd,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  left_flag,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic                  flag,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value
);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  shift_in;
  logic                  prev_own;
  logic                  a_valid;
  logic [KEY_BITS-1:0]   a_key, p_key;
  logic [VALUE_BITS-1:0] a_value, p_value;

  // a_*: this position once the gap is closed; p_*: the position to the left of it
  always_comb begin
    shift_in = cmd.rm && (cell_pos >= cmd.idx);
    prev_own = cmd.rm && (cell_pos > cmd.idx);
    a_key    = shift_in ? right_key   : key_r;
    a_value  = shift_in ? right_value : value_r;
    p_key    = prev_own ? key_r   : left_key;
    p_value  = prev_own ? value_r : left_value;
    a_valid  = CNT_W'(cell_pos) < cmd.cnt_rm;
    // set from the insert position onwards (ordering is monotone along the row)
    flag     = !a_valid || (a_key > cmd.key);

    key_nxt   = a_key;
    value_nxt = a_value;
    if (cmd.ins) begin
      if (flag && !left_flag) begin
        key_nxt   = cmd.key;
        value_nxt = cmd.value;
      end else if (flag) begin
        key_nxt   = p_key;
        value_nxt = p_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

  assign key   = key_r;
  assign value = value_r;

endmodule

/* rtl/sorted_array_priority_queue.sv */
`timescale 1ns / 1ps
// An input transfer's result is registered into the output register.
// Throughput: one op per cycle unless stalled; OK ops update all cells that cycle.
// An input is taken while the output register is empty or being drained.
// Reset clears occupancy, sets capacity to 16 and empties the output register;
// entry contents are not reset.

module sorted_array_priority_queue
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [KEY_BITS-1:0]   in_new_key,
  input  logic [VALUE_BITS-1:0] in_new_value,
  input  logic [IDX_W-1:0]      in_entry_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]      out_occupancy
);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cap_r;
  logic [CNT_W-1:0]      cap_eff;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r, value_res;
  status_t               out_status_r, status_res;
  logic [CNT_W-1:0]      out_occ_r;
  logic                  in_xfer;
  op_t                   op;
  logic [IDX_W-1:0]      sel_idx;
  logic [VALUE_BITS-1:0] sel_value;
  cmd_t                  cmd;

  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic                  cell_flag  [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign op        = op_t'(in_opcode);
  assign cap_eff   = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;
  assign sel_idx   = (op == OP_EXTRACT) ? '0 : in_entry_index;
  assign sel_value = cell_value[sel_idx];

  always_comb begin
    status_res = ST_OK;
    value_res  = '0;
    count_nxt  = count_r;
    cmd.rm     = 1'b0;
    cmd.ins    = 1'b0;
    cmd.idx    = sel_idx;
    cmd.key    = in_new_key;
    cmd.value  = in_new_value;
    unique case (op) inside
      OP_INSERT: begin
        if (count_r >= cap_eff || count_r >= CNT_W'(DEPTH)) begin
          status_res = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE, OP_EXTRACT: begin
        if (CNT_W'(sel_idx) >= count_r) begin
          status_res = ST_RANGE;
        end else begin
          cmd.rm    = 1'b1;
          value_res = sel_value;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_CHANGE: begin
        if (CNT_W'(sel_idx) >= count_r) begin
          status_res = ST_RANGE;
        end else begin
          cmd.rm    = 1'b1;
          cmd.ins   = 1'b1;
          cmd.value = sel_value;
        end
      end
      default: status_res = ST_RANGE;
    endcase
    cmd.cnt_rm = count_r - CNT_W'(cmd.rm);
    cmd.upd    = in_xfer && (status_res == ST_OK);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]   lk, rk;
    logic [VALUE_BITS-1:0] lv, rv;
    logic                  lf;

    if (g == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
      assign lf = 1'b0;
    end else begin : g_mid_l
      assign lk = cell_key[g-1];
      assign lv = cell_value[g-1];
      assign lf = cell_flag[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_mid_r
      assign rk = cell_key[g+1];
      assign rv = cell_value[g+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cell_pos    (IDX_W'(g)),
      .cmd         (cmd),
      .left_key    (lk),
      .left_value  (lv),
      .left_flag   (lf),
      .right_key   (rk),
      .right_value (rv),
      .flag        (cell_flag[g]),
      .key         (cell_key[g]),
      .value       (cell_value[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_value_r  <= value_res;
      out_status_r <= status_res;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule
